// File: src/tspcpf_pkg.sv
// Package for the caption PID finder: constants, packet phase encoding and the
// run descriptor handed from the parser to the result emitter. No dependencies.
`timescale 1ns / 1ps
package tspcpf_pkg;

  localparam int PktLen     = 188;
  localparam int MaxPmtPids = 32;
  localparam int MaxCapPids = 8;
  localparam int PmtIdxW    = $clog2(MaxPmtPids);
  localparam int PmtCntW    = PmtIdxW + 1;
  localparam int CapIdxW    = $clog2(MaxCapPids);
  localparam int CapCntW    = CapIdxW + 1;
  localparam int PosW       = 10;

  localparam logic [7:0] SYNC_BYTE     = 8'h47;
  localparam logic [7:0] LAST_POS      = 8'(PktLen - 1);
  localparam logic [7:0] TID_PAT       = 8'h00;
  localparam logic [7:0] TID_PMT       = 8'h02;
  localparam logic [7:0] ST_MPEG1_VID  = 8'h01;
  localparam logic [7:0] ST_MPEG2_VID  = 8'h02;
  localparam logic [7:0] ST_PRIVATE    = 8'h06;
  localparam logic [7:0] DESC_STREAM_ID = 8'h52;
  localparam logic [7:0] TAG_CAP_LO    = 8'h30;
  localparam logic [7:0] TAG_CAP_HI    = 8'h37;

  typedef logic [12:0]     pid_t;
  typedef logic [PosW-1:0] pos_t;

  typedef enum logic [5:0] {
    PH_HDR  = 6'b000001,
    PH_PTR  = 6'b000010,
    PH_SEC  = 6'b000100,
    PH_PAT  = 6'b001000,
    PH_PMT  = 6'b010000,
    PH_SKIP = 6'b100000
  } phase_t;

  typedef struct packed {
    logic                        fire;
    logic [15:0]                 service;
    pid_t                        video;
    logic [CapCntW-1:0]          count;
    logic [MaxCapPids-1:0][12:0] caps;
  } run_t;

  function automatic pos_t sat_pos(input logic [12:0] v);
    return (v > 13'((1 << PosW) - 1)) ? '1 : v[PosW-1:0];
  endfunction

endpackage

// File: src/tspcpf_in_reg.sv
// Input register stage: holds one stream beat until the parser takes it.
// Depends on nothing beyond the clock and reset.
`timescale 1ns / 1ps
module tspcpf_in_reg (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  input  logic       take,
  output logic       item_valid,
  output logic [7:0] item_byte,
  output logic       item_last
);

  logic       valid_r;
  logic [7:0] byte_r;
  logic       last_r;

  assign in_tready  = !valid_r || take;
  assign item_valid = valid_r;
  assign item_byte  = byte_r;
  assign item_last  = last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      valid_r <= 1'b1;
    end else if (take) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      byte_r <= in_byte;
      last_r <= in_last;
    end
  end

endmodule

// File: src/tspcpf_parser.sv
// Byte-serial PAT/PMT parser with PMT PID and caption PID tables.
// Uses tspcpf_pkg; table additions commit on the last byte of each packet.
`timescale 1ns / 1ps
module tspcpf_parser
  import tspcpf_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       take,
  input  logic [7:0] item_byte,
  input  logic       item_last,
  output run_t       run
);

  logic [7:0]         idx_r, idx_nxt;
  phase_t             phase_r, phase_nxt;
  logic               ok_r, ok_nxt;
  pid_t               pid_r, pid_nxt;
  logic               known_r, known_nxt;
  logic [7:0]         ptr_r, ptr_nxt;
  logic [7:0]         sec_r, sec_nxt;
  logic [3:0]         len_hi_r, len_hi_nxt;
  logic [7:0]         end_r, end_nxt;
  logic               prog_nz_r, prog_nz_nxt;
  logic [4:0]         pid_hi_r, pid_hi_nxt;
  logic [7:0]         svc_hi_r, svc_hi_nxt;
  logic [3:0]         info_hi_r, info_hi_nxt;
  logic               es_run_r, es_run_nxt;
  pos_t               es_q_r, es_q_nxt;
  logic [7:0]         es_type_r, es_type_nxt;
  pid_t               es_pid_r, es_pid_nxt;
  logic               es_body_r, es_body_nxt;
  logic [3:0]         dlen_hi_r, dlen_hi_nxt;
  pos_t               d_r, d_nxt;
  pos_t               dend_r, dend_nxt;
  logic               desc_on_r, desc_on_nxt;
  logic [7:0]         tag_r, tag_nxt;
  logic               armed_r, armed_nxt;
  logic [7:0]         arm_pos_r, arm_pos_nxt;
  logic               capf_r, capf_nxt;
  logic [PmtCntW-1:0] pmt_cnt_w_r, pmt_cnt_w_nxt, pmt_cnt_c_r, pmt_cnt_c_nxt;
  logic [CapCntW-1:0] cap_cnt_w_r, cap_cnt_w_nxt, cap_cnt_c_r, cap_cnt_c_nxt;
  logic [15:0]        svc_w_r, svc_w_nxt, svc_c_r, svc_c_nxt;
  pid_t               vid_w_r, vid_w_nxt, vid_c_r, vid_c_nxt;
  logic               fin_r, fin_nxt;
  pid_t               pmt_tab_r [MaxPmtPids];
  pid_t               pmt_tab_nxt [MaxPmtPids];
  pid_t               cap_tab_r [MaxCapPids];
  pid_t               cap_tab_nxt [MaxCapPids];

  logic [7:0]  p, b, rel;
  logic [8:0]  o_af;
  logic [9:0]  o2, diff;
  logic [12:0] sec_len_end;
  logic        known_hit, cap_now, endes, dup, commit, pkt_emit;
  logic [10:0] d_plus1;

  always_comb begin
    p = idx_r;
    b = item_byte;
    idx_nxt = idx_r;       phase_nxt = phase_r;   ok_nxt = ok_r;
    pid_nxt = pid_r;       known_nxt = known_r;   ptr_nxt = ptr_r;
    sec_nxt = sec_r;       len_hi_nxt = len_hi_r; end_nxt = end_r;
    prog_nz_nxt = prog_nz_r; pid_hi_nxt = pid_hi_r; svc_hi_nxt = svc_hi_r;
    info_hi_nxt = info_hi_r; es_run_nxt = es_run_r; es_q_nxt = es_q_r;
    es_type_nxt = es_type_r; es_pid_nxt = es_pid_r; es_body_nxt = es_body_r;
    dlen_hi_nxt = dlen_hi_r; d_nxt = d_r; dend_nxt = dend_r;
    desc_on_nxt = desc_on_r; tag_nxt = tag_r; armed_nxt = armed_r;
    arm_pos_nxt = arm_pos_r; capf_nxt = capf_r;
    pmt_cnt_w_nxt = pmt_cnt_w_r; pmt_cnt_c_nxt = pmt_cnt_c_r;
    cap_cnt_w_nxt = cap_cnt_w_r; cap_cnt_c_nxt = cap_cnt_c_r;
    svc_w_nxt = svc_w_r; svc_c_nxt = svc_c_r;
    vid_w_nxt = vid_w_r; vid_c_nxt = vid_c_r;
    fin_nxt = fin_r;
    for (int k = 0; k < MaxPmtPids; k++) pmt_tab_nxt[k] = pmt_tab_r[k];
    for (int k = 0; k < MaxCapPids; k++) cap_tab_nxt[k] = cap_tab_r[k];

    rel         = p - sec_r;
    o_af        = 9'd5 + {1'b0, b};
    o2          = {2'b0, p} + 10'd1 + {2'b0, b};
    sec_len_end = {5'b0, sec_r} + {len_hi_r, b} - 13'd1;
    diff        = {2'b0, p} - es_q_r;
    d_plus1     = {1'b0, d_r} + 11'd1;
    known_hit   = 1'b0;
    for (int k = 0; k < MaxPmtPids; k++) begin
      if (PmtCntW'(k) < pmt_cnt_c_r && pmt_tab_r[k] == {pid_r[12:8], b}) known_hit = 1'b1;
    end
    cap_now  = capf_r;
    endes    = 1'b0;
    dup      = 1'b0;
    commit   = 1'b0;
    pkt_emit = 1'b0;

    if (take && !fin_r) begin
      idx_nxt = (p == LAST_POS) ? 8'd0 : p + 8'd1;
      unique case (phase_r)
        PH_HDR: begin
          priority if (p == 8'd0) begin
            ok_nxt = (b == SYNC_BYTE);
          end else if (p == 8'd1) begin
            ok_nxt = ok_r && b[6];
            pid_nxt = {b[4:0], 8'd0};
          end else if (p == 8'd2) begin
            pid_nxt = {pid_r[12:8], b};
            known_nxt = known_hit;
          end else if (p == 8'd3) begin
            if (!(ok_r && b[4])) begin
              phase_nxt = PH_SKIP;
            end else if (!b[5]) begin
              ptr_nxt = 8'd4;
              phase_nxt = PH_PTR;
            end
          end else begin
            if (o_af >= 9'(PktLen)) begin
              phase_nxt = PH_SKIP;
            end else begin
              ptr_nxt = o_af[7:0];
              phase_nxt = PH_PTR;
            end
          end
        end
        PH_PTR: begin
          if (p == ptr_r) begin
            if (o2 + 10'd12 > 10'(PktLen)) begin
              phase_nxt = PH_SKIP;
            end else begin
              sec_nxt = o2[7:0];
              phase_nxt = PH_SEC;
            end
          end
        end
        PH_SEC: begin
          if (p == sec_r) begin
            priority if (pid_r == '0 && b == TID_PAT) begin
              phase_nxt = PH_PAT;
            end else if (known_r && b == TID_PMT) begin
              phase_nxt = PH_PMT;
            end else begin
              phase_nxt = PH_SKIP;
            end
          end
        end
        PH_PAT, PH_PMT: begin
          if (rel == 8'd1) len_hi_nxt = b[3:0];
          if (rel == 8'd2) begin
            end_nxt = (sec_len_end > 13'(PktLen)) ? 8'(PktLen) : sec_len_end[7:0];
          end
          if (phase_r == PH_PAT) begin
            if (rel >= 8'd8) begin
              unique case (rel[1:0])
                2'd0: prog_nz_nxt = (b != 8'd0);
                2'd1: prog_nz_nxt = prog_nz_r || (b != 8'd0);
                2'd2: pid_hi_nxt = b[4:0];
                default: begin
                  if (p < end_r && prog_nz_r && pmt_cnt_w_r < PmtCntW'(MaxPmtPids)) begin
                    pmt_tab_nxt[pmt_cnt_w_r[PmtIdxW-1:0]] = {pid_hi_r, b};
                    pmt_cnt_w_nxt = pmt_cnt_w_r + 1'b1;
                  end
                end
              endcase
            end
          end else begin
            if (rel == 8'd3) svc_hi_nxt = b;
            if (rel == 8'd4 && svc_w_r == 16'd0) svc_w_nxt = {svc_hi_r, b};
            if (rel == 8'd10) info_hi_nxt = b[3:0];
            if (rel == 8'd11) begin
              es_q_nxt = sat_pos({5'b0, p} + 13'd1 + {1'b0, info_hi_r, b});
              es_run_nxt = 1'b1;
            end
            if (es_run_r) begin
              if (armed_r && p == arm_pos_r) begin
                cap_now = (b >= TAG_CAP_LO) && (b <= TAG_CAP_HI);
                armed_nxt = 1'b0;
                capf_nxt = cap_now;
              end
              endes = es_body_r && ({2'b0, p} == es_q_r || p == LAST_POS);
              if (endes) begin
                es_body_nxt = 1'b0;
                desc_on_nxt = 1'b0;
                if (es_type_r == ST_PRIVATE && cap_now) begin
                  for (int k = 0; k < MaxCapPids; k++) begin
                    if (CapCntW'(k) < cap_cnt_w_r && cap_tab_r[k] == es_pid_r) dup = 1'b1;
                  end
                  if (!dup && cap_cnt_w_r < CapCntW'(MaxCapPids)) begin
                    cap_tab_nxt[cap_cnt_w_r[CapIdxW-1:0]] = es_pid_r;
                    cap_cnt_w_nxt = cap_cnt_w_r + 1'b1;
                  end
                end
              end
              if ({2'b0, p} >= es_q_r && diff < 10'd5) begin
                unique case (diff[2:0])
                  3'd0: es_type_nxt = b;
                  3'd1: es_pid_nxt = {b[4:0], 8'd0};
                  3'd2: es_pid_nxt = {es_pid_r[12:8], b};
                  3'd3: dlen_hi_nxt = b[3:0];
                  3'd4: begin
                    if (p < end_r) begin
                      if ((es_type_r == ST_MPEG1_VID || es_type_r == ST_MPEG2_VID)
                          && vid_w_r == '0) begin
                        vid_w_nxt = es_pid_r;
                      end
                      es_body_nxt = 1'b1;
                      desc_on_nxt = 1'b1;
                      capf_nxt = 1'b0;
                      armed_nxt = 1'b0;
                      d_nxt = sat_pos({5'b0, p} + 13'd1);
                      dend_nxt = sat_pos({5'b0, p} + 13'd1 + {1'b0, dlen_hi_r, b});
                      es_q_nxt = dend_nxt;
                    end else begin
                      es_run_nxt = 1'b0;
                    end
                  end
                  default: es_run_nxt = es_run_r;
                endcase
              end
              if (es_body_r && desc_on_r && !endes) begin
                if ({2'b0, p} == d_r) tag_nxt = b;
                if ({3'b0, p} == d_plus1) begin
                  if ({2'b0, p} + 10'd1 <= dend_r && p < end_r) begin
                    if (tag_r == DESC_STREAM_ID && b != 8'd0 && p < LAST_POS) begin
                      armed_nxt = 1'b1;
                      arm_pos_nxt = p + 8'd1;
                    end
                    d_nxt = sat_pos({5'b0, p} + 13'd1 + {5'b0, b});
                  end else begin
                    desc_on_nxt = 1'b0;
                  end
                end
              end
            end
          end
        end
        PH_SKIP: phase_nxt = PH_SKIP;
        default: phase_nxt = PH_HDR;
      endcase

      if (p == LAST_POS) begin
        commit = 1'b1;
        pkt_emit = (phase_r == PH_PMT) && cap_cnt_w_nxt != '0 && vid_w_nxt != '0;
        pmt_cnt_c_nxt = pmt_cnt_w_nxt;
        cap_cnt_c_nxt = cap_cnt_w_nxt;
        svc_c_nxt = svc_w_nxt;
        vid_c_nxt = vid_w_nxt;
        phase_nxt = PH_HDR;
        es_run_nxt = 1'b0;
        es_body_nxt = 1'b0;
        desc_on_nxt = 1'b0;
        armed_nxt = 1'b0;
        if (pkt_emit) fin_nxt = 1'b1;
      end
    end

    run.fire    = take && !fin_r && (pkt_emit || item_last);
    run.service = commit ? svc_w_nxt : svc_c_r;
    run.video   = commit ? vid_w_nxt : vid_c_r;
    run.count   = commit ? cap_cnt_w_nxt : cap_cnt_c_r;
    for (int k = 0; k < MaxCapPids; k++) run.caps[k] = cap_tab_nxt[k];

    if (take && item_last) begin
      idx_nxt = 8'd0;        phase_nxt = PH_HDR;
      es_run_nxt = 1'b0;     es_body_nxt = 1'b0;
      desc_on_nxt = 1'b0;    armed_nxt = 1'b0;
      pmt_cnt_w_nxt = '0;    pmt_cnt_c_nxt = '0;
      cap_cnt_w_nxt = '0;    cap_cnt_c_nxt = '0;
      svc_w_nxt = '0;        svc_c_nxt = '0;
      vid_w_nxt = '0;        vid_c_nxt = '0;
      fin_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;       phase_r <= PH_HDR;
      es_run_r <= 1'b0;  es_body_r <= 1'b0;
      desc_on_r <= 1'b0; armed_r <= 1'b0;
      pmt_cnt_w_r <= '0; pmt_cnt_c_r <= '0;
      cap_cnt_w_r <= '0; cap_cnt_c_r <= '0;
      svc_w_r <= '0;     svc_c_r <= '0;
      vid_w_r <= '0;     vid_c_r <= '0;
      fin_r <= 1'b0;
    end else begin
      idx_r <= idx_nxt;             phase_r <= phase_nxt;
      es_run_r <= es_run_nxt;       es_body_r <= es_body_nxt;
      desc_on_r <= desc_on_nxt;     armed_r <= armed_nxt;
      pmt_cnt_w_r <= pmt_cnt_w_nxt; pmt_cnt_c_r <= pmt_cnt_c_nxt;
      cap_cnt_w_r <= cap_cnt_w_nxt; cap_cnt_c_r <= cap_cnt_c_nxt;
      svc_w_r <= svc_w_nxt;         svc_c_r <= svc_c_nxt;
      vid_w_r <= vid_w_nxt;         vid_c_r <= vid_c_nxt;
      fin_r <= fin_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ok_r <= ok_nxt;           pid_r <= pid_nxt;         known_r <= known_nxt;
    ptr_r <= ptr_nxt;         sec_r <= sec_nxt;         len_hi_r <= len_hi_nxt;
    end_r <= end_nxt;         prog_nz_r <= prog_nz_nxt; pid_hi_r <= pid_hi_nxt;
    svc_hi_r <= svc_hi_nxt;   info_hi_r <= info_hi_nxt; es_q_r <= es_q_nxt;
    es_type_r <= es_type_nxt; es_pid_r <= es_pid_nxt;   dlen_hi_r <= dlen_hi_nxt;
    d_r <= d_nxt;             dend_r <= dend_nxt;       tag_r <= tag_nxt;
    arm_pos_r <= arm_pos_nxt; capf_r <= capf_nxt;
    for (int k = 0; k < MaxPmtPids; k++) pmt_tab_r[k] <= pmt_tab_nxt[k];
    for (int k = 0; k < MaxCapPids; k++) cap_tab_r[k] <= cap_tab_nxt[k];
  end

endmodule

// File: src/tspcpf_emitter.sv
// Result emitter: captures a run snapshot and sends one result beat per
// caption PID, or one empty beat. Uses tspcpf_pkg.
`timescale 1ns / 1ps
module tspcpf_emitter
  import tspcpf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  run_t        run,
  output logic        busy,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,
  output logic        out_tuser,
  output logic        out_tlast
);

  logic                        busy_r;
  logic [CapIdxW-1:0]          k_r;
  logic [15:0]                 svc_r;
  pid_t                        vid_r;
  logic [CapCntW-1:0]          cnt_r;
  logic [MaxCapPids-1:0][12:0] caps_r;
  logic                        has_cap, last_beat;
  pid_t                        cap_pid;

  assign has_cap   = (cnt_r != '0);
  assign last_beat = !has_cap || ({1'b0, k_r} + 1'b1 == cnt_r);
  assign cap_pid   = has_cap ? caps_r[k_r] : '0;

  assign busy       = busy_r;
  assign out_tvalid = busy_r;
  assign out_tdata  = {6'd0, cap_pid, vid_r, svc_r};
  assign out_tuser  = has_cap;
  assign out_tlast  = last_beat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      k_r    <= '0;
    end else if (run.fire) begin
      busy_r <= 1'b1;
      k_r    <= '0;
    end else if (busy_r && out_tready) begin
      if (last_beat) begin
        busy_r <= 1'b0;
      end else begin
        k_r <= k_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (run.fire) begin
      svc_r  <= run.service;
      vid_r  <= run.video;
      cnt_r  <= run.count;
      caps_r <= run.caps;
    end
  end

endmodule

// File: src/ts_psi_caption_pid_finder_top.sv
// Caption PID finder top level: input register, PAT/PMT parser, result emitter.
// The beat that completes the run passes the input register, then fire loads the emitter's result registers.
// Throughput: one stream byte per cycle; input stalls while a run of 1 to 8
// result beats drains, one beat per cycle while out_tready is high.
// Reset: synchronous active-low rst_n clears all table counts and control state, not the table contents.
`timescale 1ns / 1ps
module ts_psi_caption_pid_finder_top
  import tspcpf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] ts_byte
  input  logic        in_tlast,   // capture_end
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [15:0] service_id, [28:16] video_pid, [41:29] caption_pid
  output logic        out_tuser,  // [0] caption_valid
  output logic        out_tlast   // run_last
);

  logic       item_valid, item_last, take, busy;
  logic [7:0] item_byte;
  run_t       run;

  assign take = item_valid && !busy;

  tspcpf_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_byte    (in_tdata),
    .in_last    (in_tlast),
    .take       (take),
    .item_valid (item_valid),
    .item_byte  (item_byte),
    .item_last  (item_last)
  );

  tspcpf_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (take),
    .item_byte (item_byte),
    .item_last (item_last),
    .run       (run)
  );

  tspcpf_emitter u_emitter (
    .clk        (clk),
    .rst_n      (rst_n),
    .run        (run),
    .busy       (busy),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
